// ===== hdl/ssnf_pkg.sv =====
// Shared types, constants and segment encoding for the seven-segment number formatter.
package ssnf_pkg;

  // Display geometry
  localparam int DIGITS = 6;
  localparam int SLOT_W = 3;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [3:0]          digit_t;
  typedef logic [7:0]          seg_t;
  typedef digit_t [DIGITS-1:0] digits_t;
  typedef seg_t   [DIGITS-1:0] frame_t;

  localparam slot_t LAST_SLOT = slot_t'(DIGITS - 1);

  // Special segment bytes
  localparam seg_t SEG_BLANK = 8'h00;
  localparam seg_t SEG_MINUS = 8'h40;
  localparam seg_t SEG_POINT = 8'h80;

  // floor(x / 10) == (x * RECIP10) >> RECIP10_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int          RECIP10_SHIFT = 35;

  // Digit index carried in each transmit slot (display shows groups of three reversed)
  localparam logic [SLOT_W-1:0] SEND_ORDER [DIGITS] = '{3'd2, 3'd1, 3'd0, 3'd5, 3'd4, 3'd3};

  // Bookkeeping carried alongside an item through the front pipeline
  typedef struct packed {
    logic       neg;
    logic       keep;
    logic [3:0] point;
    logic       blank;
  } meta_t;

  // Segment pattern for a decimal digit; codes above nine mean nothing
  function automatic seg_t seg_code(input digit_t d);
    seg_t s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/ssnf_front.sv =====
// Front end: accepts numbers, splits the magnitude into digits and builds segment frames.
module ssnf_front import ssnf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_value,
  input  logic        in_keep_leading_zeros,
  input  logic [3:0]  in_point_digit,
  input  logic        in_blank_last_two,
  output logic        frame_push,
  output frame_t      frame,
  input  logic        frame_full
);

  localparam int STAGES = DIGITS + 2;  // input, six divide stages, digit stage
  localparam int LAST   = STAGES - 1;

  logic             valid_r [STAGES];
  meta_t            meta_r  [STAGES];
  logic [31:0]      x_r     [STAGES];
  logic [63:0]      prod_r  [STAGES];
  digits_t          dig_r   [STAGES];
  digits_t          dig_nxt [STAGES];

  logic             adv;
  logic             accept;
  logic [31:0]      mag;
  logic [31:0]      nx      [DIGITS+1];
  digit_t           rem     [DIGITS+1];

  // Whole pipeline holds while a finished frame cannot enter the queue
  assign adv     = !(valid_r[LAST] && frame_full);
  assign in_full = !adv;
  assign accept  = in_push && adv;

  // Magnitude; the most negative value maps to 2^31
  assign mag = in_value[31] ? (~in_value + 32'd1) : in_value;

  // Quotient and remainder out of each registered reciprocal product
  always_comb begin
    nx[0]  = x_r[0];
    rem[0] = '0;
    for (int k = 1; k <= DIGITS; k++) begin
      nx[k]  = 32'(prod_r[k][63:RECIP10_SHIFT]);
      rem[k] = digit_t'(x_r[k] - ((nx[k] << 3) + (nx[k] << 1)));
    end
  end

  // Digit vector of each stage with the digit found one stage earlier dropped in
  always_comb begin
    dig_nxt[0] = '0;
    for (int s = 1; s < STAGES; s++) begin
      dig_nxt[s] = dig_r[s-1];
      if (s > 1) dig_nxt[s][DIGITS+1-s] = rem[s-1];
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STAGES; s++) valid_r[s] <= 1'b0;
    end else if (adv) begin
      valid_r[0] <= accept;
      for (int s = 1; s < STAGES; s++) valid_r[s] <= valid_r[s-1];
    end
  end

  // Pipeline payload: one divide by ten per stage, least significant digit first
  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]    <= mag;
      meta_r[0] <= '{neg: in_value[31], keep: in_keep_leading_zeros,
                     point: in_point_digit, blank: in_blank_last_two};
      prod_r[0] <= '0;
      for (int s = 0; s < STAGES; s++) dig_r[s] <= dig_nxt[s];
      for (int s = 1; s < STAGES; s++) begin
        meta_r[s] <= meta_r[s-1];
        x_r[s]    <= nx[s-1];
        prod_r[s] <= 64'(nx[s-1]) * 64'(RECIP10);
      end
    end
  end

  // Classification: leading-zero limit, sign, point and blanking
  always_comb begin
    meta_t            m;
    logic             has_point;
    logic [2:0]       first;
    logic             found;
    seg_t [DIGITS-1:0] by_digit;
    m         = meta_r[LAST];
    has_point = !m.point[3];
    first     = 3'(DIGITS - 1);
    found     = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      if (!found && dig_r[LAST][i] != '0) begin
        first = 3'(i);
        found = 1'b1;
      end
    end
    if (has_point && first > m.point[2:0]) first = m.point[2:0];

    for (int d = 0; d < DIGITS; d++) begin
      if (m.blank && d >= DIGITS - 2) begin
        by_digit[d] = SEG_BLANK;
      end else if (d == 0 && m.neg) begin
        by_digit[d] = SEG_MINUS;
      end else if (m.keep || 3'(d) >= first) begin
        by_digit[d] = seg_code(dig_r[LAST][d]);
        if (has_point && m.point[2:0] == 3'(d)) by_digit[d] = by_digit[d] | SEG_POINT;
      end else begin
        by_digit[d] = SEG_BLANK;
      end
    end

    for (int p = 0; p < DIGITS; p++) frame[p] = by_digit[SEND_ORDER[p]];
  end

  assign frame_push = valid_r[LAST] && !frame_full;

endmodule

// ===== hdl/ssnf_queue.sv =====
// Short frame queue between the front end and the byte serializer.
module ssnf_queue import ssnf_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  frame_t wr_frame,
  output logic   full,
  input  logic   pop,
  output frame_t rd_frame,
  output logic   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t             store [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push, do_pop;

  assign full     = count_r == CNT_W'(DEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_frame = store[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  // Frame storage
  always_ff @(posedge clk) begin
    if (do_push) store[wr_ptr_r] <= wr_frame;
  end

endmodule

// ===== hdl/ssnf_back.sv =====
// Back end: sends one segment byte per transfer from the frame at the queue head.
module ssnf_back import ssnf_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  frame_t q_frame,
  input  logic   q_empty,
  output logic   q_pop,
  output logic   out_empty,
  input  logic   out_pop,
  output seg_t   out_segments,
  output slot_t  out_slot,
  output logic   out_last
);

  frame_t frame_r;
  slot_t  slot_r;
  logic   busy_r;
  logic   take;

  // Load the next frame when idle or as the last byte leaves
  assign take  = !busy_r || (out_pop && slot_r == LAST_SLOT);
  assign q_pop = take && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      slot_r <= '0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      slot_r <= '0;
    end else if (take) begin
      busy_r <= 1'b0;
    end else if (out_pop) begin
      slot_r <= slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) frame_r <= q_frame;
  end

  assign out_empty    = !busy_r;
  assign out_segments = frame_r[slot_r];
  assign out_slot     = slot_r;
  assign out_last     = slot_r == LAST_SLOT;

endmodule

// ===== hdl/seven_segment_number_formatter.sv =====
// Each accepted number yields a frame of six segment bytes, slots 0..5 carrying digits
// 2,1,0,5,4,3, with last set on slot 5. The result side moves one byte per transfer, so
// the sustained rate is one number every six transfers; the front end takes a new number
// every cycle until a finished frame finds the frame queue (QUEUE_DEPTH frames) full, then
// full stays high until the serializer frees an entry. A number passes the input stage,
// which registers it at the transfer, seven further stages for the six divide-by-ten
// steps and the digit step, then one queue write and one serializer load before its
// first byte appears. Six digits of the magnitude are shown (a minus replaces the top one
// of a negative number), so magnitudes above 999999 show their low six digits.
module seven_segment_number_formatter import ssnf_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_value,
  input  logic        in_keep_leading_zeros,
  input  logic [3:0]  in_point_digit,
  input  logic        in_blank_last_two,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_segments,
  output logic [2:0]  out_slot,
  output logic        out_last
);

  frame_t f_frame, q_frame;
  logic   f_push, q_full, q_empty, q_pop;

  // Digit extraction and frame building
  ssnf_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_push               (in_push),
    .in_full               (in_full),
    .in_value              (in_value),
    .in_keep_leading_zeros (in_keep_leading_zeros),
    .in_point_digit        (in_point_digit),
    .in_blank_last_two     (in_blank_last_two),
    .frame_push            (f_push),
    .frame                 (f_frame),
    .frame_full            (q_full)
  );

  // Frame queue
  ssnf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .wr_frame (f_frame),
    .full     (q_full),
    .pop      (q_pop),
    .rd_frame (q_frame),
    .empty    (q_empty)
  );

  // Byte serializer
  ssnf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_frame      (q_frame),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_segments (out_segments),
    .out_slot     (out_slot),
    .out_last     (out_last)
  );

  // The front end stalls only on a full queue
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> q_full)
    else $error("input stalled without a full frame queue");

  // A transfer of a byte inside a frame is followed by the next slot
  a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_last) |=>
      (!out_empty && out_slot == 3'($past(out_slot) + 3'd1)))
    else $error("frame slot did not advance after a transfer");

  // A queued frame is never left waiting while the serializer is idle
  a_no_idle_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (out_empty && !q_empty) |-> q_pop)
    else $error("serializer idle with a frame queued");

endmodule

// ===== bench/seven_segment_number_formatter_tb.sv =====
// Self-checking testbench for the six-digit seven-segment number formatter.
module seven_segment_number_formatter_tb;
  import ssnf_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 30;
  localparam logic [3:0] NO_POINT = 4'hF;

  // One expected segment byte of a frame
  typedef struct packed {
    seg_t  segments;
    slot_t slot;
    logic  last;
  } frame_byte_t;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [31:0] in_value;
  logic        in_keep_leading_zeros;
  logic [3:0]  in_point_digit;
  logic        in_blank_last_two;
  logic        out_empty;
  logic        out_pop;
  logic [7:0]  out_segments;
  logic [2:0]  out_slot;
  logic        out_last;

  frame_byte_t pending_bytes[$];
  int          send_idle_pct;
  int          pop_idle_pct;
  int          numbers_sent;
  int          bytes_checked;
  int          error_count;
  int          cycle_count;

  seven_segment_number_formatter DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_push               (in_push),
    .in_full               (in_full),
    .in_value              (in_value),
    .in_keep_leading_zeros (in_keep_leading_zeros),
    .in_point_digit        (in_point_digit),
    .in_blank_last_two     (in_blank_last_two),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_segments          (out_segments),
    .out_slot              (out_slot),
    .out_last              (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Segment pattern of a decimal digit
  function automatic seg_t digit_pattern(input int d);
    case (d)
      0: return 8'h3F;
      1: return 8'h06;
      2: return 8'h5B;
      3: return 8'h4F;
      4: return 8'h66;
      5: return 8'h6D;
      6: return 8'h7D;
      7: return 8'h07;
      8: return 8'h7F;
      default: return 8'h6F;
    endcase
  endfunction

  // Expected frame for one number: six bytes in display order 2,1,0,5,4,3
  function automatic void predict_frame(input logic [31:0] value, input logic keep,
                                        input logic [3:0] point_code, input logic blank);
    logic        negative;
    logic [31:0] mag;
    logic        has_point;
    int          point;
    int          digit [DIGITS];
    int          first;
    int          d;
    frame_byte_t fb;
    negative  = value[31];
    mag       = negative ? (~value + 32'd1) : value;
    has_point = !point_code[3];
    point     = int'(point_code[2:0]);
    for (int i = DIGITS - 1; i >= 0; i--) begin
      digit[i] = int'(mag % 32'd10);
      mag      = mag / 32'd10;
    end
    // first shown digit under suppression, pulled forward to the point
    first = DIGITS - 1;
    if (!keep) begin
      for (int i = DIGITS - 1; i >= 0; i--) begin
        if (digit[i] != 0) first = i;
      end
      if (has_point && first > point) first = point;
    end
    for (int pos = 0; pos < DIGITS; pos++) begin
      d = (pos < 3) ? 2 - pos : 8 - pos;
      if (blank && d >= 4) begin
        fb.segments = SEG_BLANK;
      end else if (d == 0 && negative) begin
        fb.segments = SEG_MINUS;
      end else if (keep || d >= first) begin
        fb.segments = digit_pattern(digit[d]);
        if (has_point && d == point) fb.segments = fb.segments | SEG_POINT;
      end else begin
        fb.segments = SEG_BLANK;
      end
      fb.slot = slot_t'(pos);
      fb.last = (pos == DIGITS - 1);
      pending_bytes.push_back(fb);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0d] mismatch: %s", cycle_count, msg);
    error_count++;
  endtask

  // Push one number, with random idle cycles ahead of it
  task automatic send_number(input logic [31:0] value, input logic keep,
                             input logic [3:0] point_code, input logic blank);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push               = 1'b0;
      in_value              = $urandom();
      in_keep_leading_zeros = 1'($urandom_range(1));
      in_point_digit        = 4'($urandom_range(15));
      in_blank_last_two     = 1'($urandom_range(1));
      @(negedge clk);
    end
    in_push               = 1'b1;
    in_value              = value;
    in_keep_leading_zeros = keep;
    in_point_digit        = point_code;
    in_blank_last_two     = blank;
    forever begin
      @(posedge clk);
      if (!in_full) break;
    end
    predict_frame(value, keep, point_code, blank);
    numbers_sent++;
  endtask

  // Random number: mixes short, long, round and boundary magnitudes
  function automatic logic [31:0] pick_value();
    logic [31:0] mag;
    logic [31:0] limit;
    int          digits;
    limit  = 32'd1;
    digits = $urandom_range(6);
    repeat (digits) limit = limit * 32'd10;
    case ($urandom_range(5))
      0: return $urandom();
      1: mag = $urandom_range(999999);
      2: mag = $urandom_range(limit - 1);
      3: mag = $urandom_range(9) * limit;
      4: begin
        case ($urandom_range(5))
          0: mag = 32'd0;
          1: mag = 32'd999999;
          2: mag = 32'd1000000;
          3: mag = 32'h7FFF_FFFF;
          4: mag = 32'h8000_0000;
          default: mag = limit;
        endcase
      end
      default: mag = $urandom_range(32'h7FFF_FFFF, 32'd1000000);
    endcase
    return ($urandom_range(2) == 0) ? -mag : mag;
  endfunction

  // Receiver: random pop requests at the falling edge
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      out_pop = ($urandom_range(99) >= pop_idle_pct);
    end
  end

  // Compare each transfer on the result side with the oldest expected byte
  always @(posedge clk) begin
    frame_byte_t exp_byte;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h slot %0d", out_segments, out_slot));
      end else begin
        exp_byte = pending_bytes.pop_front();
        bytes_checked++;
        if (out_segments !== exp_byte.segments)
          report_mismatch($sformatf("segments %02h, want %02h (slot %0d)",
                                    out_segments, exp_byte.segments, exp_byte.slot));
        if (out_slot !== exp_byte.slot)
          report_mismatch($sformatf("slot %0d, want %0d", out_slot, exp_byte.slot));
        if (out_last !== exp_byte.last)
          report_mismatch($sformatf("last %0b, want %0b (slot %0d)",
                                    out_last, exp_byte.last, exp_byte.slot));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes outstanding",
               cycle_count, pending_bytes.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Zero handling and leading-zero suppression
  task automatic test_zero_suppression();
    send_number(32'd0, 1'b0, NO_POINT, 1'b0);
    send_number(32'd0, 1'b1, NO_POINT, 1'b0);
    send_number(32'd0, 1'b0, 4'd2, 1'b0);
    send_number(32'd123, 1'b0, NO_POINT, 1'b0);
    send_number(32'd100200, 1'b0, NO_POINT, 1'b0);
    send_number(32'd1000000, 1'b0, NO_POINT, 1'b0);
    send_number(32'd999999, 1'b1, NO_POINT, 1'b0);
  endtask

  // Sign, minus digit and value extremes
  task automatic test_sign_handling();
    send_number(32'h7FFF_FFFF, 1'b0, NO_POINT, 1'b0);
    send_number(32'h8000_0001, 1'b0, NO_POINT, 1'b0);
    send_number(32'h8000_0000, 1'b0, NO_POINT, 1'b0);
    send_number(-32'sd1, 1'b0, NO_POINT, 1'b0);
    send_number(-32'sd1, 1'b1, NO_POINT, 1'b0);
    send_number(-32'sd123456, 1'b0, 4'd0, 1'b0);
  endtask

  // Decimal point on every digit, out-of-range codes and no point
  task automatic test_decimal_point();
    for (int p = 0; p < 8; p++) send_number(32'd123, 1'b0, 4'(p), 1'b0);
    send_number(32'd42, 1'b0, 4'd8, 1'b0);
    send_number(32'd999999, 1'b1, 4'd0, 1'b0);
  endtask

  // Blanking of the two low digits
  task automatic test_blanking();
    send_number(32'd654321, 1'b0, 4'd4, 1'b1);
    send_number(-32'sd5, 1'b1, 4'd5, 1'b1);
    send_number(32'd7, 1'b0, 4'hE, 1'b1);
  endtask

  task automatic test_random_numbers(input int count);
    repeat (count)
      send_number(pick_value(), 1'($urandom_range(1)), 4'($urandom_range(15)),
                  $urandom_range(3) == 0);
  endtask

  initial begin
    rst_n                 = 1'b0;
    in_push               = 1'b0;
    in_value              = '0;
    in_keep_leading_zeros = 1'b0;
    in_point_digit        = '0;
    in_blank_last_two     = 1'b0;
    send_idle_pct         = 38;
    pop_idle_pct          = 85;
    numbers_sent          = 0;
    bytes_checked         = 0;
    error_count           = 0;
    cycle_count           = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // slow receiver
    test_zero_suppression();
    test_sign_handling();
    test_decimal_point();
    test_blanking();
    test_random_numbers(100);
    // slow sender
    send_idle_pct = 85;
    pop_idle_pct  = 38;
    test_random_numbers(100);
    // full rate on both sides
    send_idle_pct = 0;
    pop_idle_pct  = 0;
    test_random_numbers(100);

    @(negedge clk);
    in_push = 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d numbers (%0d segment bytes) under three idle patterns",
             numbers_sent, bytes_checked);
    $display("mismatches: %0d", error_count);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ssnf_pkg.sv
hdl/ssnf_front.sv
hdl/ssnf_queue.sv
hdl/ssnf_back.sv
hdl/seven_segment_number_formatter.sv
bench/seven_segment_number_formatter_tb.sv
